[design/odr_pkg.sv]
// Shared widths, types, codes and helpers for the dead-reckoning estimator.
package odr_pkg;

    localparam int POS_W     = 32;
    localparam int QUAT_W    = 16;
    localparam int ROT_SHIFT = 2 * (QUAT_W - 2);

    // shared multiplier
    localparam int MUL_W  = 32;
    localparam int PROD_W = 2 * MUL_W;

    // sum of squared deltas and its root
    localparam int SUM_W     = 2 * POS_W + 2;
    localparam int ROOT_W    = SUM_W / 2;
    localparam int ISQ_CNT_W = $clog2(ROOT_W + 1);

    // rotation column, product accumulator, scaled term, estimate sum
    localparam int COL_W     = 2 * QUAT_W + 3;
    localparam int CMAG_W    = COL_W - 1;
    localparam int ACC_W     = ROOT_W + CMAG_W + 1;
    localparam int TERM_W    = ACC_W - ROT_SHIFT + 1;
    localparam int EST_SUM_W = TERM_W + 1;

    localparam int STEP_W = 4;

    typedef logic signed [POS_W-1:0]  pos_t;
    typedef logic signed [QUAT_W-1:0] quat_t;
    typedef logic signed [COL_W-1:0]  col_t;
    typedef logic signed [TERM_W-1:0] term_t;

    // function codes
    localparam logic FUNC_IMU  = 1'b0;
    localparam logic FUNC_ODOM = 1'b1;

    // quaternion component slots
    localparam logic [1:0] QI_X = 2'd0;
    localparam logic [1:0] QI_Y = 2'd1;
    localparam logic [1:0] QI_Z = 2'd2;
    localparam logic [1:0] QI_W = 2'd3;

    // quaternion product slots, in issue order
    localparam logic [STEP_W-1:0] PR_YY = 4'd0;
    localparam logic [STEP_W-1:0] PR_ZZ = 4'd1;
    localparam logic [STEP_W-1:0] PR_XY = 4'd2;
    localparam logic [STEP_W-1:0] PR_WZ = 4'd3;
    localparam logic [STEP_W-1:0] PR_XZ = 4'd4;
    localparam logic [STEP_W-1:0] PR_WY = 4'd5;

    // partial products of length * |coef| (length half, coef half)
    localparam logic [1:0] PP_LO_LO = 2'd0;
    localparam logic [1:0] PP_LO_HI = 2'd1;
    localparam logic [1:0] PP_HI_LO = 2'd2;
    localparam logic [1:0] PP_HI_HI = 2'd3;

    // sequencer step counts (last issue + one drain step)
    localparam logic [STEP_W-1:0] SQ_STEPS    = 4'd3;
    localparam logic [STEP_W-1:0] COL_STEPS   = 4'd6;
    localparam logic [STEP_W-1:0] SCALE_STEPS = 4'd12;

    localparam quat_t             QUAT_ONE   = QUAT_W'(1) << (QUAT_W - 2);
    localparam col_t              ROT_ONE    = COL_W'(1) << ROT_SHIFT;
    localparam logic [ACC_W-1:0]  ROUND_HALF = ACC_W'(1) << (ROT_SHIFT - 1);
    localparam logic signed [EST_SUM_W-1:0] SAT_HI =
        EST_SUM_W'({1'b0, {(POS_W-1){1'b1}}});
    localparam logic signed [EST_SUM_W-1:0] SAT_LO = ~SAT_HI;
    localparam pos_t POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam pos_t POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SQ    = 7'b0000010,
        S_COL   = 7'b0000100,
        S_ROOT  = 7'b0001000,
        S_SCALE = 7'b0010000,
        S_SUM   = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    typedef struct packed {
        logic [1:0] a;
        logic [1:0] b;
    } pair_t;

    // operand slots of each quaternion product
    function automatic pair_t col_pair(input logic [STEP_W-1:0] j);
        pair_t pr;
        unique case (j)
            PR_YY:   pr = '{a: QI_Y, b: QI_Y};
            PR_ZZ:   pr = '{a: QI_Z, b: QI_Z};
            PR_XY:   pr = '{a: QI_X, b: QI_Y};
            PR_WZ:   pr = '{a: QI_W, b: QI_Z};
            PR_XZ:   pr = '{a: QI_X, b: QI_Z};
            PR_WY:   pr = '{a: QI_W, b: QI_Y};
            default: pr = '{a: QI_X, b: QI_X};
        endcase
        return pr;
    endfunction

endpackage

[design/odometry_dead_reckoning_top.sv]
// Top level of the dead-reckoning position estimator with quaternion heading.
// Orientation items and the first position sample go straight to S_DONE and raise out_valid
// from there; a later position sample first passes the square, column, root and scale steps.
// One item is in flight at a time; in_ready is high only while idle, so the core takes no
// new transaction until it has handed the last one to the output register.
// The output register frees the core to take the next transaction while a result
// waits for out_ready.
// Reset: estimate zero, orientation identity, no prior sample, no result pending.
module odometry_dead_reckoning_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                func,
    input  logic signed [odr_pkg::QUAT_W-1:0]   quat_x,
    input  logic signed [odr_pkg::QUAT_W-1:0]   quat_y,
    input  logic signed [odr_pkg::QUAT_W-1:0]   quat_z,
    input  logic signed [odr_pkg::QUAT_W-1:0]   quat_w,
    input  logic signed [odr_pkg::POS_W-1:0]    pos_x,
    input  logic signed [odr_pkg::POS_W-1:0]    pos_y,
    input  logic signed [odr_pkg::POS_W-1:0]    pos_z,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [odr_pkg::POS_W-1:0]    est_x,
    output logic signed [odr_pkg::POS_W-1:0]    est_y,
    output logic signed [odr_pkg::POS_W-1:0]    est_z,
    output logic signed [odr_pkg::QUAT_W-1:0]   cur_qx,
    output logic signed [odr_pkg::QUAT_W-1:0]   cur_qy,
    output logic signed [odr_pkg::QUAT_W-1:0]   cur_qz,
    output logic signed [odr_pkg::QUAT_W-1:0]   cur_qw,
    output logic                                est_valid
);

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    odr_pkg::state_t                 state_reg, state_next;
    logic [odr_pkg::STEP_W-1:0]      step_reg, step_next, prev_step;

    // Architectural state
    odr_pkg::pos_t                   est_reg   [3];
    odr_pkg::pos_t                   prior_reg [3];
    odr_pkg::pos_t                   cur_reg   [3];
    odr_pkg::quat_t                  quat_reg  [4];
    logic                            first_reg;

    // Working registers
    logic [odr_pkg::SUM_W-1:0]       sum_reg, sum_next;
    odr_pkg::col_t                   col_reg [3];
    odr_pkg::col_t                   col_next [3];
    logic [odr_pkg::ACC_W-1:0]       acc_reg, acc_next;
    odr_pkg::term_t                  term_reg [3];

    // Output register
    logic                            out_valid_reg;
    odr_pkg::pos_t                   out_est_reg [3];
    odr_pkg::quat_t                  out_q_reg   [4];
    logic                            out_flag_reg;

    // Datapath nets
    logic signed [odr_pkg::POS_W:0]  diff [3];
    logic [odr_pkg::POS_W-1:0]       dmag [3];
    logic [odr_pkg::CMAG_W-1:0]      cmag [3];
    logic [odr_pkg::QUAT_W-1:0]      qmag [4];
    logic [odr_pkg::POS_W-1:0]       sel_dmag;
    logic [odr_pkg::CMAG_W-1:0]      sel_cmag;

    logic [odr_pkg::MUL_W-1:0]       mul_a, mul_b;
    logic [odr_pkg::PROD_W-1:0]      mul_p;

    logic                            isq_start, isq_busy;
    logic [odr_pkg::ROOT_W-1:0]      isq_root;
    logic [odr_pkg::MUL_W-1:0]       len_lo, len_hi;

    odr_pkg::pair_t                  pair_cur, pair_prev;
    logic                            prod_neg;
    odr_pkg::col_t                   twice, sprod;

    logic [1:0]                      term_idx, part_idx;
    logic                            term_neg, term_wr;
    logic [odr_pkg::ACC_W-1:0]       addend, acc_sum, rnd;
    odr_pkg::term_t                  term_val;

    logic signed [odr_pkg::EST_SUM_W-1:0] est_sum [3];
    odr_pkg::pos_t                   est_sat [3];

    logic                            in_fire, out_load;

    // ------------------------------------------------------------------
    // Shared units
    // ------------------------------------------------------------------
    odr_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    odr_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (isq_start),
        .rad   (sum_next),
        .busy  (isq_busy),
        .root  (isq_root)
    );

    assign in_ready  = (state_reg == odr_pkg::S_IDLE);
    assign in_fire   = in_valid & in_ready;
    assign prev_step = step_reg - odr_pkg::STEP_W'(1);
    assign len_lo    = isq_root[odr_pkg::MUL_W-1:0];
    assign len_hi    = odr_pkg::MUL_W'(isq_root[odr_pkg::ROOT_W-1:odr_pkg::MUL_W]);

    // ------------------------------------------------------------------
    // Magnitudes of deltas, column entries and quaternion components
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            diff[i] = {cur_reg[i][odr_pkg::POS_W-1], cur_reg[i]}
                    - {prior_reg[i][odr_pkg::POS_W-1], prior_reg[i]};
            // |delta| < 2^POS_W, so the magnitude fits POS_W bits
            dmag[i] = diff[i][odr_pkg::POS_W] ? odr_pkg::POS_W'(-diff[i])
                                              : odr_pkg::POS_W'(diff[i]);
            cmag[i] = col_reg[i][odr_pkg::COL_W-1] ? odr_pkg::CMAG_W'(-col_reg[i])
                                                   : odr_pkg::CMAG_W'(col_reg[i]);
        end
        for (int i = 0; i < 4; i++)
        begin
            qmag[i] = quat_reg[i][odr_pkg::QUAT_W-1] ? odr_pkg::QUAT_W'(-quat_reg[i])
                                                     : odr_pkg::QUAT_W'(quat_reg[i]);
        end
    end

    // ------------------------------------------------------------------
    // Operand selection and product alignment
    // ------------------------------------------------------------------
    always_comb
    begin
        term_idx = prev_step[3:2];
        part_idx = prev_step[1:0];
        sel_dmag = '0;
        sel_cmag = '0;
        term_neg = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            if (step_reg == odr_pkg::STEP_W'(i))
                sel_dmag = dmag[i];
            if (step_reg[3:2] == 2'(i))
                sel_cmag = cmag[i];
            if (term_idx == 2'(i))
                term_neg = col_reg[i][odr_pkg::COL_W-1];
        end

        pair_cur  = odr_pkg::col_pair(step_reg);
        pair_prev = odr_pkg::col_pair(prev_step);
        prod_neg  = quat_reg[pair_prev.a][odr_pkg::QUAT_W-1]
                  ^ quat_reg[pair_prev.b][odr_pkg::QUAT_W-1];
        // products are at most 2^30, doubled fits well inside the column width
        twice     = odr_pkg::COL_W'({mul_p[odr_pkg::MUL_W-1:0], 1'b0});
        sprod     = prod_neg ? -twice : twice;

        case (part_idx) inside
            odr_pkg::PP_LO_LO:
                addend = odr_pkg::ACC_W'(mul_p);
            odr_pkg::PP_LO_HI, odr_pkg::PP_HI_LO:
                addend = odr_pkg::ACC_W'(mul_p) << odr_pkg::MUL_W;
            default:
                addend = odr_pkg::ACC_W'(mul_p) << (2 * odr_pkg::MUL_W);
        endcase
        acc_sum  = acc_reg + addend;
        // round to nearest on the magnitude: ties go away from zero
        rnd      = acc_sum + odr_pkg::ROUND_HALF;
        term_val = term_neg
                 ? -odr_pkg::TERM_W'(rnd[odr_pkg::ACC_W-1:odr_pkg::ROT_SHIFT])
                 :  odr_pkg::TERM_W'(rnd[odr_pkg::ACC_W-1:odr_pkg::ROT_SHIFT]);
    end

    // ------------------------------------------------------------------
    // Saturating estimate update
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            est_sum[i] = odr_pkg::EST_SUM_W'(est_reg[i])
                       + odr_pkg::EST_SUM_W'(term_reg[i]);
            if (est_sum[i] > odr_pkg::SAT_HI)
                est_sat[i] = odr_pkg::POS_MAX;
            else if (est_sum[i] < odr_pkg::SAT_LO)
                est_sat[i] = odr_pkg::POS_MIN;
            else
                est_sat[i] = odr_pkg::POS_W'(est_sum[i]);
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    //   S_SQ    : three squared deltas through the multiplier, summed
    //   S_COL   : six quaternion products build the rotation column,
    //             while the square root runs alongside
    //   S_ROOT  : wait for the root
    //   S_SCALE : four partial products per axis, rounded to Q16.16
    //   S_SUM   : saturating add into the estimate, latch prior position
    //   S_DONE  : hand the result to the output register
    // Each multiply phase issues on steps 0..N-1 and accumulates the
    // registered product on the following step.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        sum_next   = sum_reg;
        col_next   = col_reg;
        acc_next   = acc_reg;
        mul_a      = '0;
        mul_b      = '0;
        isq_start  = 1'b0;
        term_wr    = 1'b0;
        out_load   = 1'b0;

        unique case (state_reg)
            odr_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    step_next = '0;
                    sum_next  = '0;
                    if (func == odr_pkg::FUNC_ODOM && !first_reg)
                        state_next = odr_pkg::S_SQ;
                    else
                        state_next = odr_pkg::S_DONE;
                end
            end

            odr_pkg::S_SQ:
            begin
                if (step_reg < odr_pkg::SQ_STEPS)
                begin
                    mul_a = sel_dmag;
                    mul_b = sel_dmag;
                end
                if (step_reg != '0)
                    sum_next = sum_reg + odr_pkg::SUM_W'(mul_p);
                if (step_reg == odr_pkg::SQ_STEPS)
                begin
                    isq_start   = 1'b1;
                    state_next  = odr_pkg::S_COL;
                    step_next   = '0;
                    col_next[0] = odr_pkg::ROT_ONE;
                    col_next[1] = '0;
                    col_next[2] = '0;
                end
                else
                begin
                    step_next = step_reg + odr_pkg::STEP_W'(1);
                end
            end

            odr_pkg::S_COL:
            begin
                if (step_reg < odr_pkg::COL_STEPS)
                begin
                    mul_a = odr_pkg::MUL_W'(qmag[pair_cur.a]);
                    mul_b = odr_pkg::MUL_W'(qmag[pair_cur.b]);
                end
                if (step_reg != '0)
                begin
                    case (prev_step) inside
                        odr_pkg::PR_YY, odr_pkg::PR_ZZ:
                            col_next[0] = col_reg[0] - sprod;
                        odr_pkg::PR_XY, odr_pkg::PR_WZ:
                            col_next[1] = col_reg[1] + sprod;
                        odr_pkg::PR_XZ:
                            col_next[2] = col_reg[2] + sprod;
                        odr_pkg::PR_WY:
                            col_next[2] = col_reg[2] - sprod;
                        default:
                            col_next = col_reg;
                    endcase
                end
                if (step_reg == odr_pkg::COL_STEPS)
                begin
                    state_next = odr_pkg::S_ROOT;
                    step_next  = '0;
                end
                else
                begin
                    step_next = step_reg + odr_pkg::STEP_W'(1);
                end
            end

            odr_pkg::S_ROOT:
            begin
                if (!isq_busy)
                begin
                    state_next = odr_pkg::S_SCALE;
                    step_next  = '0;
                    acc_next   = '0;
                end
            end

            odr_pkg::S_SCALE:
            begin
                if (step_reg < odr_pkg::SCALE_STEPS)
                begin
                    mul_a = step_reg[1] ? len_hi : len_lo;
                    mul_b = step_reg[0]
                          ? odr_pkg::MUL_W'(sel_cmag[odr_pkg::CMAG_W-1:odr_pkg::MUL_W])
                          : sel_cmag[odr_pkg::MUL_W-1:0];
                end
                if (step_reg != '0)
                begin
                    acc_next = acc_sum;
                    if (part_idx == odr_pkg::PP_HI_HI)
                    begin
                        term_wr  = 1'b1;
                        acc_next = '0;
                    end
                end
                if (step_reg == odr_pkg::SCALE_STEPS)
                begin
                    state_next = odr_pkg::S_SUM;
                    step_next  = '0;
                end
                else
                begin
                    step_next = step_reg + odr_pkg::STEP_W'(1);
                end
            end

            odr_pkg::S_SUM:
            begin
                state_next = odr_pkg::S_DONE;
            end

            odr_pkg::S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = odr_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = odr_pkg::S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control and architectural state with reset
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= odr_pkg::S_IDLE;
            step_reg      <= '0;
            first_reg     <= 1'b1;
            est_reg       <= '{default: '0};
            quat_reg[odr_pkg::QI_X] <= '0;
            quat_reg[odr_pkg::QI_Y] <= '0;
            quat_reg[odr_pkg::QI_Z] <= '0;
            quat_reg[odr_pkg::QI_W] <= odr_pkg::QUAT_ONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;

            if (in_fire)
            begin
                if (func == odr_pkg::FUNC_IMU)
                begin
                    quat_reg[odr_pkg::QI_X] <= quat_x;
                    quat_reg[odr_pkg::QI_Y] <= quat_y;
                    quat_reg[odr_pkg::QI_Z] <= quat_z;
                    quat_reg[odr_pkg::QI_W] <= quat_w;
                end
                else
                begin
                    first_reg <= 1'b0;
                end
            end

            if (state_reg == odr_pkg::S_SUM)
                est_reg <= est_sat;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers (prior position is only read once written)
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        col_reg <= col_next;
        acc_reg <= acc_next;

        if (term_wr)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (term_idx == 2'(i))
                    term_reg[i] <= term_val;
            end
        end

        if (in_fire && func == odr_pkg::FUNC_ODOM)
        begin
            cur_reg[0] <= pos_x;
            cur_reg[1] <= pos_y;
            cur_reg[2] <= pos_z;
            if (first_reg)
            begin
                prior_reg[0] <= pos_x;
                prior_reg[1] <= pos_y;
                prior_reg[2] <= pos_z;
            end
        end

        if (state_reg == odr_pkg::S_SUM)
            prior_reg <= cur_reg;

        if (out_load)
        begin
            out_est_reg  <= est_reg;
            out_q_reg    <= quat_reg;
            out_flag_reg <= !first_reg;
        end
    end

    // ------------------------------------------------------------------
    // Result transaction
    // ------------------------------------------------------------------
    assign out_valid = out_valid_reg;
    assign est_x     = out_est_reg[0];
    assign est_y     = out_est_reg[1];
    assign est_z     = out_est_reg[2];
    assign cur_qx    = out_q_reg[odr_pkg::QI_X];
    assign cur_qy    = out_q_reg[odr_pkg::QI_Y];
    assign cur_qz    = out_q_reg[odr_pkg::QI_Z];
    assign cur_qw    = out_q_reg[odr_pkg::QI_W];
    assign est_valid = out_flag_reg;

endmodule

[design/odr_mul.sv]
// Shared unsigned multiplier with a registered product.
module odr_mul (
    input  logic                         clk,
    input  logic [odr_pkg::MUL_W-1:0]    a,
    input  logic [odr_pkg::MUL_W-1:0]    b,
    output logic [odr_pkg::PROD_W-1:0]   p
);

    logic [odr_pkg::PROD_W-1:0] p_reg;
    logic [odr_pkg::PROD_W-1:0] p_next;

    assign p_next = a * b;

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

[design/odr_isqrt.sv]
// Iterative integer square root, one root bit per cycle.
module odr_isqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [odr_pkg::SUM_W-1:0]     rad,
    output logic                          busy,
    output logic [odr_pkg::ROOT_W-1:0]    root
);

    localparam int REM_W = odr_pkg::ROOT_W + 2;
    localparam int SH_W  = REM_W + 2;

    logic [odr_pkg::SUM_W-1:0]      rad_reg;
    logic [REM_W-1:0]               rem_reg;
    logic [odr_pkg::ROOT_W-1:0]     q_reg;
    logic [odr_pkg::ISQ_CNT_W-1:0]  cnt_reg;

    logic [SH_W-1:0] shifted;
    logic [SH_W-1:0] trial;
    logic [SH_W-1:0] diff;
    logic            take;

    assign busy = (cnt_reg != '0);
    assign root = q_reg;

    // bring down the next two radicand bits, try appending a one
    always_comb
    begin
        shifted = {rem_reg, rad_reg[odr_pkg::SUM_W-1 -: 2]};
        trial   = SH_W'({q_reg, 2'b01});
        take    = (shifted >= trial);
        diff    = shifted - trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= odr_pkg::ISQ_CNT_W'(odr_pkg::ROOT_W);
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - odr_pkg::ISQ_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg <= rad;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (busy)
        begin
            rad_reg <= {rad_reg[odr_pkg::SUM_W-3:0], 2'b00};
            rem_reg <= take ? diff[REM_W-1:0] : shifted[REM_W-1:0];
            q_reg   <= {q_reg[odr_pkg::ROOT_W-2:0], take};
        end
    end

endmodule

[tb/testbench.sv]
// Self-checking testbench for the dead-reckoning estimator: directed rows, then random traffic.
module testbench;

    // One input transaction, one field per port.
    typedef struct {
        logic           func;
        odr_pkg::quat_t qx;
        odr_pkg::quat_t qy;
        odr_pkg::quat_t qz;
        odr_pkg::quat_t qw;
        odr_pkg::pos_t  px;
        odr_pkg::pos_t  py;
        odr_pkg::pos_t  pz;
    } odo_txn_t;

    // One result transaction: estimate, stored orientation, valid flag.
    typedef struct {
        odr_pkg::pos_t  ex;
        odr_pkg::pos_t  ey;
        odr_pkg::pos_t  ez;
        odr_pkg::quat_t qx;
        odr_pkg::quat_t qy;
        odr_pkg::quat_t qz;
        odr_pkg::quat_t qw;
        logic           valid;
    } odo_est_t;

    // Directed row: the transaction and, where it is obvious, a hand-typed result.
    typedef struct {
        odo_txn_t txn;
        logic     typed;
        odo_est_t want;
    } plan_row_t;

    logic           clk = 1'b0;
    logic           rst_n;
    logic           in_valid;
    logic           in_ready;
    logic           func;
    odr_pkg::quat_t quat_x;
    odr_pkg::quat_t quat_y;
    odr_pkg::quat_t quat_z;
    odr_pkg::quat_t quat_w;
    odr_pkg::pos_t  pos_x;
    odr_pkg::pos_t  pos_y;
    odr_pkg::pos_t  pos_z;
    logic           out_valid;
    logic           out_ready;
    odr_pkg::pos_t  est_x;
    odr_pkg::pos_t  est_y;
    odr_pkg::pos_t  est_z;
    odr_pkg::quat_t cur_qx;
    odr_pkg::quat_t cur_qy;
    odr_pkg::quat_t cur_qz;
    odr_pkg::quat_t cur_qw;
    logic           est_valid;

    // Predictor state: running estimate, last latched position, heading, first-fix flag.
    odr_pkg::pos_t  acc_est  [3];
    odr_pkg::pos_t  last_pos [3];
    odr_pkg::quat_t heading  [4];
    logic           no_fix_yet;

    odo_est_t      pending_est [$];
    plan_row_t     dir_plan [$];
    odr_pkg::pos_t walk_pos [3];
    int            err_cnt = 0;
    int            sender_idle_pct = 0;
    int            rx_stall_pct = 0;

    odometry_dead_reckoning_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .quat_x    (quat_x),
        .quat_y    (quat_y),
        .quat_z    (quat_z),
        .quat_w    (quat_w),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .est_x     (est_x),
        .est_y     (est_y),
        .est_z     (est_z),
        .cur_qx    (cur_qx),
        .cur_qy    (cur_qy),
        .cur_qz    (cur_qz),
        .cur_qw    (cur_qw),
        .est_valid (est_valid)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Orientation item; the position fields are don't-care and get junk.
    function automatic odo_txn_t mk_imu(input int qx, input int qy, input int qz, input int qw);
        odo_txn_t t;
        t.func = odr_pkg::FUNC_IMU;
        t.qx   = odr_pkg::quat_t'(qx);
        t.qy   = odr_pkg::quat_t'(qy);
        t.qz   = odr_pkg::quat_t'(qz);
        t.qw   = odr_pkg::quat_t'(qw);
        t.px   = odr_pkg::pos_t'($urandom);
        t.py   = odr_pkg::pos_t'($urandom);
        t.pz   = odr_pkg::pos_t'($urandom);
        return t;
    endfunction

    // Position sample; the quaternion fields are don't-care and get junk.
    function automatic odo_txn_t mk_odom(input odr_pkg::pos_t px, input odr_pkg::pos_t py,
                                         input odr_pkg::pos_t pz);
        odo_txn_t t;
        t.func = odr_pkg::FUNC_ODOM;
        t.qx   = odr_pkg::quat_t'($urandom);
        t.qy   = odr_pkg::quat_t'($urandom);
        t.qz   = odr_pkg::quat_t'($urandom);
        t.qw   = odr_pkg::quat_t'($urandom);
        t.px   = px;
        t.py   = py;
        t.pz   = pz;
        return t;
    endfunction

    function automatic odo_est_t mk_est(input int ex, input int ey, input int ez,
                                        input int qx, input int qy, input int qz,
                                        input int qw, input logic v);
        odo_est_t e;
        e.ex    = odr_pkg::pos_t'(ex);
        e.ey    = odr_pkg::pos_t'(ey);
        e.ez    = odr_pkg::pos_t'(ez);
        e.qx    = odr_pkg::quat_t'(qx);
        e.qy    = odr_pkg::quat_t'(qy);
        e.qz    = odr_pkg::quat_t'(qz);
        e.qw    = odr_pkg::quat_t'(qw);
        e.valid = v;
        return e;
    endfunction

    task automatic plan_checked(input odo_txn_t t, input odo_est_t w);
        plan_row_t r;
        r.txn   = t;
        r.typed = 1'b1;
        r.want  = w;
        dir_plan.push_back(r);
    endtask

    task automatic plan_predicted(input odo_txn_t t);
        plan_row_t r;
        r.txn   = t;
        r.typed = 1'b0;
        r.want  = mk_est(0, 0, 0, 0, 0, 0, 0, 1'b0);
        dir_plan.push_back(r);
    endtask

    // Advance the estimator state by one transaction and return the result it yields.
    function automatic odo_est_t dead_reckon(input odo_txn_t t);
        odr_pkg::pos_t cur [3];
        longint       qv [4];
        longint       coef [3];
        longint       dlt;
        longint       acc;
        longint       term;
        logic [63:0]  umag;
        logic [127:0] sumsq;
        logic [127:0] root;
        logic [127:0] cand;
        logic [127:0] prod;
        odo_est_t     r;
        int           i;
        int           b;
        if (t.func == odr_pkg::FUNC_IMU)
        begin
            heading[0] = t.qx;
            heading[1] = t.qy;
            heading[2] = t.qz;
            heading[3] = t.qw;
        end
        else
        begin
            cur[0] = t.px;
            cur[1] = t.py;
            cur[2] = t.pz;
            if (no_fix_yet)
            begin
                // first sample only latches the prior position
                no_fix_yet = 1'b0;
            end
            else
            begin
                // exact sum of squared deltas
                sumsq = '0;
                for (i = 0; i < 3; i++)
                begin
                    dlt   = longint'(cur[i]) - longint'(last_pos[i]);
                    umag  = (dlt < 0) ? -dlt : dlt;
                    sumsq = sumsq + {64'd0, umag} * {64'd0, umag};
                end
                // floor square root, bit by bit
                root = '0;
                for (b = odr_pkg::POS_W + 2; b >= 0; b--)
                begin
                    cand = root | (128'd1 << b);
                    if (cand * cand <= sumsq)
                        root = cand;
                end
                // first column of the rotation matrix, not renormalized
                for (i = 0; i < 4; i++)
                    qv[i] = longint'(heading[i]);
                coef[0] = (longint'(1) <<< odr_pkg::ROT_SHIFT)
                        - 2 * (qv[1] * qv[1] + qv[2] * qv[2]);
                coef[1] = 2 * (qv[0] * qv[1] + qv[3] * qv[2]);
                coef[2] = 2 * (qv[0] * qv[2] - qv[3] * qv[1]);
                // scale back with round half away from zero, then saturate
                for (i = 0; i < 3; i++)
                begin
                    umag = (coef[i] < 0) ? -coef[i] : coef[i];
                    prod = root * {64'd0, umag} + (128'd1 << (odr_pkg::ROT_SHIFT - 1));
                    term = longint'(prod[odr_pkg::ROT_SHIFT +: 64]);
                    if (coef[i] < 0)
                        term = -term;
                    acc = longint'(acc_est[i]) + term;
                    if (acc > longint'(odr_pkg::POS_MAX))
                        acc_est[i] = odr_pkg::POS_MAX;
                    else if (acc < longint'(odr_pkg::POS_MIN))
                        acc_est[i] = odr_pkg::POS_MIN;
                    else
                        acc_est[i] = odr_pkg::pos_t'(acc);
                end
            end
            for (i = 0; i < 3; i++)
                last_pos[i] = cur[i];
        end
        r.ex    = acc_est[0];
        r.ey    = acc_est[1];
        r.ez    = acc_est[2];
        r.qx    = heading[0];
        r.qy    = heading[1];
        r.qz    = heading[2];
        r.qw    = heading[3];
        r.valid = ~no_fix_yet;
        return r;
    endfunction

    // Present one transaction, with an optional random gap first, and log its result
    // once accepted. A hand-typed result replaces the predicted one where given.
    task automatic drive_txn(input odo_txn_t t, input logic typed, input odo_est_t want);
        odo_est_t pred;
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= t.func;
        quat_x   <= t.qx;
        quat_y   <= t.qy;
        quat_z   <= t.qz;
        quat_w   <= t.qw;
        pos_x    <= t.px;
        pos_y    <= t.py;
        pos_z    <= t.pz;
        do
            @(posedge clk);
        while (!in_ready);
        pred = dead_reckon(t);
        pending_est.push_back(typed ? want : pred);
    endtask

    // Result side: random backpressure, compare each accepted result with the oldest one logged.
    always @(posedge clk)
    begin : rx_side
        odo_est_t got;
        odo_est_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got.ex    = est_x;
                got.ey    = est_y;
                got.ez    = est_z;
                got.qx    = cur_qx;
                got.qy    = cur_qy;
                got.qz    = cur_qz;
                got.qw    = cur_qw;
                got.valid = est_valid;
                if (pending_est.size() == 0)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("unexpected result: est=(%0d,%0d,%0d) q=(%0d,%0d,%0d,%0d) v=%b",
                                 got.ex, got.ey, got.ez, got.qx, got.qy, got.qz, got.qw,
                                 got.valid);
                end
                else
                begin
                    want = pending_est.pop_front();
                    if (got.ex !== want.ex || got.ey !== want.ey || got.ez !== want.ez ||
                        got.qx !== want.qx || got.qy !== want.qy || got.qz !== want.qz ||
                        got.qw !== want.qw || got.valid !== want.valid)
                    begin
                        err_cnt++;
                        if (err_cnt <= 10)
                        begin
                            $display("mismatch: exp est=(%0d,%0d,%0d) q=(%0d,%0d,%0d,%0d) v=%b",
                                     want.ex, want.ey, want.ez, want.qx, want.qy, want.qz,
                                     want.qw, want.valid);
                            $display("          got est=(%0d,%0d,%0d) q=(%0d,%0d,%0d,%0d) v=%b",
                                     got.ex, got.ey, got.ez, got.qx, got.qy, got.qz,
                                     got.qw, got.valid);
                        end
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    initial
    begin : stim
        odo_txn_t      t;
        real           ra;
        real           rb;
        real           rc;
        real           rd;
        real           rn;
        int            ph;
        int            n;
        int            i;
        int            pick;
        int            sh;
        odr_pkg::pos_t step;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        func      = odr_pkg::FUNC_IMU;
        quat_x    = '0;
        quat_y    = '0;
        quat_z    = '0;
        quat_w    = '0;
        pos_x     = '0;
        pos_y     = '0;
        pos_z     = '0;
        out_ready = 1'b0;

        // predictor in its reset state
        for (i = 0; i < 3; i++)
        begin
            acc_est[i]  = '0;
            last_pos[i] = '0;
            walk_pos[i] = '0;
        end
        heading[0] = '0;
        heading[1] = '0;
        heading[2] = '0;
        heading[3] = odr_pkg::QUAT_ONE;
        no_fix_yet = 1'b1;

        // Directed rows. First sample before any orientation item: reset heading shows.
        plan_checked(mk_odom(100, 200, 300), mk_est(0, 0, 0, 0, 0, 0, 16384, 1'b1));
        // 3.0 m step along x under identity heading
        plan_checked(mk_odom(100 + 3 * 65536, 200, 300),
                     mk_est(196608, 0, 0, 0, 0, 0, 16384, 1'b1));
        // zero-length step
        plan_checked(mk_odom(100 + 3 * 65536, 200, 300),
                     mk_est(196608, 0, 0, 0, 0, 0, 16384, 1'b1));
        // negated identity; estimate untouched by an orientation item
        plan_checked(mk_imu(0, 0, 0, -16384),
                     mk_est(196608, 0, 0, 0, 0, 0, -16384, 1'b1));
        plan_predicted(mk_odom(100, 200, 300));
        plan_predicted(mk_imu(0, 0, 16384, 0));
        plan_predicted(mk_odom(100, 200 + 65536, 300));
        // non-unit, largest in-range components
        plan_predicted(mk_imu(16384, 16384, 16384, 16384));
        plan_predicted(mk_odom(odr_pkg::POS_MAX, odr_pkg::POS_MAX, odr_pkg::POS_MAX));
        plan_predicted(mk_odom(odr_pkg::POS_MIN, odr_pkg::POS_MIN, odr_pkg::POS_MIN));
        // out-of-range patterns are stored as given
        plan_predicted(mk_imu(-32768, 32767, -32768, 32767));
        plan_predicted(mk_odom(odr_pkg::POS_MAX, odr_pkg::POS_MAX, odr_pkg::POS_MAX));
        // heading that drives x negative, into the low saturation bound
        plan_predicted(mk_imu(0, 16384, 0, 0));
        plan_predicted(mk_odom(odr_pkg::POS_MIN, odr_pkg::POS_MIN, odr_pkg::POS_MIN));
        plan_predicted(mk_odom(odr_pkg::POS_MAX, odr_pkg::POS_MAX, odr_pkg::POS_MAX));
        plan_predicted(mk_imu(0, 0, 0, 0));
        plan_predicted(mk_odom(0, 0, 0));
        plan_predicted(mk_imu(-16384, -16384, -16384, -16384));
        plan_predicted(mk_odom(-1, -1, -1));
        // roughly 90 degrees of yaw
        plan_predicted(mk_imu(0, 0, 11585, 11585));
        plan_predicted(mk_odom(65536, 0, 0));
        plan_predicted(mk_imu(8192, 8192, 8192, 8192));
        plan_predicted(mk_odom(0, 65536, 0));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_plan[k])
            drive_txn(dir_plan[k].txn, dir_plan[k].typed, dir_plan[k].want);

        // Random traffic in four idling phases.
        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin sender_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin sender_idle_pct = 57; rx_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  rx_stall_pct = 57; end
                default: begin sender_idle_pct = 36; rx_stall_pct = 36; end
            endcase
            for (n = 0; n < 275; n++)
            begin
                pick = $urandom_range(99);
                if (pick < 25)
                begin
                    // unit quaternion from a random direction
                    ra = real'(int'($urandom_range(2000)) - 1000);
                    rb = real'(int'($urandom_range(2000)) - 1000);
                    rc = real'(int'($urandom_range(2000)) - 1000);
                    rd = real'(int'($urandom_range(2000)) - 1000);
                    rn = $sqrt(ra * ra + rb * rb + rc * rc + rd * rd);
                    if (rn < 1.0)
                        t = mk_imu(0, 0, 0, 16384);
                    else
                        t = mk_imu($rtoi(ra * 16384.0 / rn), $rtoi(rb * 16384.0 / rn),
                                   $rtoi(rc * 16384.0 / rn), $rtoi(rd * 16384.0 / rn));
                end
                else if (pick < 30)
                begin
                    // any 16-bit pattern
                    t = mk_imu(int'($urandom), int'($urandom), int'($urandom), int'($urandom));
                end
                else if (pick < 34)
                begin
                    t = mk_imu(int'($urandom_range(32768)) - 16384,
                               int'($urandom_range(32768)) - 16384,
                               int'($urandom_range(32768)) - 16384,
                               int'($urandom_range(32768)) - 16384);
                end
                else if (pick < 90)
                begin
                    // random walk, step sizes spread over many octaves
                    for (i = 0; i < 3; i++)
                    begin
                        sh   = $urandom_range(22);
                        step = odr_pkg::pos_t'($urandom & ((32'd1 << sh) - 1));
                        if ($urandom_range(1) == 1)
                            walk_pos[i] = walk_pos[i] - step;
                        else
                            walk_pos[i] = walk_pos[i] + step;
                    end
                    t = mk_odom(walk_pos[0], walk_pos[1], walk_pos[2]);
                end
                else
                begin
                    // jump anywhere in the position range
                    for (i = 0; i < 3; i++)
                        walk_pos[i] = odr_pkg::pos_t'($urandom);
                    t = mk_odom(walk_pos[0], walk_pos[1], walk_pos[2]);
                end
                drive_txn(t, 1'b0, mk_est(0, 0, 0, 0, 0, 0, 0, 1'b0));
            end
        end

        in_valid <= 1'b0;
        while (pending_est.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (err_cnt == 0 && pending_est.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog, several times the slowest legal run.
    initial
    begin
        #12000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

[sim.f]
design/odr_pkg.sv
design/odr_mul.sv
design/odr_isqrt.sv
design/odometry_dead_reckoning_top.sv
tb/testbench.sv
